>>> rtl/extended_gcd_assert.svh
// assertion macros for the extended gcd block
`ifndef EXTENDED_GCD_ASSERT_SVH
`define EXTENDED_GCD_ASSERT_SVH

// clocked check, masked while reset is high
`define EGCD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked check that also holds during reset
`define EGCD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> rtl/egcd_pkg.sv
`timescale 1ns / 1ps
package egcd_pkg;

   localparam int OPERAND_BITS_DEF = 31;
   localparam int OPND_W           = 31;
   localparam int GCD_W            = 31;
   localparam int COEF_W           = 32;

   // enables from the sequencer to the datapath
   typedef struct packed {
      logic ready;
      logic load;
      logic init;
      logic step;
      logic update;
      logic emit;
   } ctrl_type;

   // datapath flags
   typedef struct packed {
      logic r1_zero;
      logic cnt_nz;
   } dp_status_type;

   // everything the sequencer branches on
   typedef struct packed {
      logic          req_valid;
      logic          out_busy;
      dp_status_type dp;
   } seq_status_type;

endpackage

>>> rtl/egcd_req_if.sv
`timescale 1ns / 1ps
interface egcd_req_if import egcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OPND_W-1:0] operand_a;
   logic [OPND_W-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

>>> rtl/egcd_rsp_if.sv
`timescale 1ns / 1ps
interface egcd_rsp_if import egcd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [GCD_W-1:0]         gcd_value;
   logic signed [COEF_W-1:0] coeff_a;
   logic signed [COEF_W-1:0] coeff_b;

   modport source (output valid, output gcd_value, output coeff_a, output coeff_b,
                   input ready);
   modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b,
                   output ready);
endinterface

>>> rtl/egcd_seq.sv
`timescale 1ns / 1ps
module egcd_seq import egcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output ctrl_type       ctrl
);

   localparam logic [2:0] OP_NOP    = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1;
   localparam logic [2:0] OP_INIT   = 3'd2;
   localparam logic [2:0] OP_STEP   = 3'd3;
   localparam logic [2:0] OP_UPDATE = 3'd4;
   localparam logic [2:0] OP_EMIT   = 3'd5;

   localparam logic [2:0] JMP_NEVER    = 3'd0;
   localparam logic [2:0] JMP_ALWAYS   = 3'd1;
   localparam logic [2:0] JMP_NO_REQ   = 3'd2;
   localparam logic [2:0] JMP_R1_ZERO  = 3'd3;
   localparam logic [2:0] JMP_CNT_NZ   = 3'd4;
   localparam logic [2:0] JMP_OUT_BUSY = 3'd5;

   localparam logic [2:0] PC_LOAD = 3'd0;
   localparam logic [2:0] PC_TEST = 3'd1;
   localparam logic [2:0] PC_STEP = 3'd3;
   localparam logic [2:0] PC_EMIT = 3'd5;

   typedef struct packed {
      logic [2:0] op;
      logic [2:0] cond;
      logic [2:0] target;
   } ucode_type;

   // microprogram
   function automatic ucode_type fetch(input logic [2:0] pc);
      ucode_type w;
      case (pc)
         3'd0:    w = '{op: OP_LOAD,   cond: JMP_NO_REQ,   target: PC_LOAD};
         3'd1:    w = '{op: OP_NOP,    cond: JMP_R1_ZERO,  target: PC_EMIT};
         3'd2:    w = '{op: OP_INIT,   cond: JMP_NEVER,    target: PC_LOAD};
         3'd3:    w = '{op: OP_STEP,   cond: JMP_CNT_NZ,   target: PC_STEP};
         3'd4:    w = '{op: OP_UPDATE, cond: JMP_ALWAYS,   target: PC_TEST};
         3'd5:    w = '{op: OP_EMIT,   cond: JMP_OUT_BUSY, target: PC_EMIT};
         default: w = '{op: OP_NOP,    cond: JMP_ALWAYS,   target: PC_LOAD};
      endcase
      return w;
   endfunction

   logic [2:0] pc_ff, pc_in;
   ucode_type  uword;
   logic       take;

   assign uword = fetch(pc_ff);

   always_comb begin
      case (uword.cond)
         JMP_NEVER:    take = 1'b0;
         JMP_ALWAYS:   take = 1'b1;
         JMP_NO_REQ:   take = !status.req_valid;
         JMP_R1_ZERO:  take = status.dp.r1_zero;
         JMP_CNT_NZ:   take = status.dp.cnt_nz;
         JMP_OUT_BUSY: take = status.out_busy;
         default:      take = 1'b1;
      endcase
      pc_in = take ? uword.target : pc_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      ctrl.ready  = (uword.op == OP_LOAD);
      ctrl.load   = (uword.op == OP_LOAD) && status.req_valid;
      ctrl.init   = (uword.op == OP_INIT);
      ctrl.step   = (uword.op == OP_STEP);
      ctrl.update = (uword.op == OP_UPDATE);
      ctrl.emit   = (uword.op == OP_EMIT) && !status.out_busy;
   end

endmodule

>>> rtl/egcd_dp.sv
`timescale 1ns / 1ps
module egcd_dp import egcd_pkg::*; #(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  logic               clock,
   input  ctrl_type           ctrl,
   input  logic [OPND_W-1:0]  operand_a,
   input  logic [OPND_W-1:0]  operand_b,
   output dp_status_type      status,
   output logic [GCD_W-1:0]   gcd,
   output logic [COEF_W-1:0]  coeff_a,
   output logic [COEF_W-1:0]  coeff_b
);

   localparam int W     = OPERAND_BITS;
   localparam int CNT_W = $clog2(OPERAND_BITS);

   logic [W-1:0]      r0_ff, r0_in, r1_ff, r1_in;
   logic [W-1:0]      dvd_ff, dvd_in, rem_ff, rem_in;
   logic [COEF_W-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [COEF_W-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [COEF_W-1:0] sacc_ff, sacc_in, tacc_ff, tacc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [W:0] trial, diff;
   logic       qbit;

   // one restoring division step, quotient bits msb first
   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = trial - {1'b0, r1_ff};
   assign qbit  = !diff[W];

   always_comb begin
      r0_in   = r0_ff;
      r1_in   = r1_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      sacc_in = sacc_ff;
      tacc_in = tacc_ff;
      cnt_in  = cnt_ff;
      if (ctrl.load) begin
         r0_in = W'(operand_a);
         r1_in = W'(operand_b);
         s0_in = COEF_W'(1);
         s1_in = '0;
         t0_in = '0;
         t1_in = COEF_W'(1);
      end
      if (ctrl.init) begin
         rem_in  = '0;
         dvd_in  = r0_ff;
         sacc_in = '0;
         tacc_in = '0;
         cnt_in  = CNT_W'(W - 1);
      end
      if (ctrl.step) begin
         rem_in  = qbit ? diff[W-1:0] : trial[W-1:0];
         dvd_in  = {dvd_ff[W-2:0], 1'b0};
         // q*s1 and q*t1 built up bit by bit, modulo the coefficient width
         sacc_in = {sacc_ff[COEF_W-2:0], 1'b0} + (qbit ? s1_ff : '0);
         tacc_in = {tacc_ff[COEF_W-2:0], 1'b0} + (qbit ? t1_ff : '0);
         cnt_in  = cnt_ff - CNT_W'(1);
      end
      if (ctrl.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         s0_in = s1_ff;
         s1_in = s0_ff - sacc_ff;
         t0_in = t1_ff;
         t1_in = t0_ff - tacc_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      sacc_ff <= sacc_in;
      tacc_ff <= tacc_in;
      cnt_ff  <= cnt_in;
   end

   assign status.r1_zero = (r1_ff == '0);
   assign status.cnt_nz  = (cnt_ff != '0);
   assign gcd            = GCD_W'(r0_ff);
   assign coeff_a        = s0_ff;
   assign coeff_b        = t0_ff;

endmodule

>>> rtl/extended_gcd.sv
`timescale 1ns / 1ps
// extended_gcd: gcd and bezout coefficients of two unsigned operands
//
// req_chan carries operand_a and operand_b; a transaction is taken when
// valid and ready are both high. rsp_chan returns gcd_value, coeff_a and
// coeff_b with operand_a*coeff_a + operand_b*coeff_b = gcd_value.
// one item is worked on at a time. each euclid iteration tests the
// remainder, loads the shared shift-subtract divider, which retires one
// quotient bit per cycle, runs it over all OPERAND_BITS dividend bits and
// then updates remainders and coefficients. the number of iterations is
// at most about 45 at 31 bits, and zero when operand_b is zero.
// the result sits in an output register, so once it is loaded the block
// takes the next request while the receiver stalls; a second result waits
// in the sequencer until the register is free.
// reset (synchronous, active high) returns the sequencer to its wait step
// and empties the output register; no result is pending after reset.
module extended_gcd import egcd_pkg::*; #(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   egcd_req_if.sink   req_chan,
   egcd_rsp_if.source rsp_chan
);

`include "extended_gcd_assert.svh"

   ctrl_type       ctrl;
   dp_status_type  dp_stat;
   seq_status_type seq_stat;

   logic [GCD_W-1:0]  gcd_w;
   logic [COEF_W-1:0] ca_w, cb_w;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GCD_W-1:0]  gcd_ff;
   logic [COEF_W-1:0] ca_ff, cb_ff;
   logic              out_busy;

   // holding a result the receiver has not taken yet
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;

   assign seq_stat.req_valid = req_chan.valid;
   assign seq_stat.out_busy  = out_busy;
   assign seq_stat.dp        = dp_stat;

   // microcoded control: step counter plus control rom
   egcd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (seq_stat),
      .ctrl   (ctrl)
   );

   // remainder, divider and coefficient registers
   egcd_dp #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dp (
      .clock     (clock),
      .ctrl      (ctrl),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .status    (dp_stat),
      .gcd       (gcd_w),
      .coeff_a   (ca_w),
      .coeff_b   (cb_w)
   );

   assign req_chan.ready = ctrl.ready;

   always_comb begin
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload captured only when a finished result is handed over
   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         gcd_ff <= gcd_w;
         ca_ff  <= ca_w;
         cb_ff  <= cb_w;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.gcd_value = gcd_ff;
   assign rsp_chan.coeff_a   = ca_ff;
   assign rsp_chan.coeff_b   = cb_ff;

   // a result is only handed over once the remainder chain has ended
   `EGCD_ASSERT(a_emit_done, ctrl.emit |-> dp_stat.r1_zero, "result emitted before remainder reached zero")
   // a new result never overwrites one the receiver still holds off
   `EGCD_ASSERT(a_emit_free, ctrl.emit |-> !out_busy, "result emitted over a stalled one")
   // one item at a time: after a request transaction the input closes
   `EGCD_ASSERT(a_one_item, (req_chan.valid && req_chan.ready) |=> !req_chan.ready, "request taken while busy")
   // the sequencer never loads and emits in the same step
   `EGCD_ASSERT_ALWAYS(a_ctrl_excl, !(ctrl.load && ctrl.emit), "load and emit in the same cycle")

endmodule

>>> sim/tb_extended_gcd.sv
`timescale 1ns / 1ps
module tb_extended_gcd;
   import egcd_pkg::*;

   // random part size and the two pressure points, in accepted transactions
   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 6000;
   localparam int DRAIN_AT     = 700;
   // longest euclid chain at 31 bits is about 45 division steps
   localparam int SETTLE_CYCLES = 2 * (45 * (OPND_W + 3) + 2);

   typedef struct packed {
      logic [OPND_W-1:0] a;
      logic [OPND_W-1:0] b;
   } operand_pair_type;

   typedef struct packed {
      logic [GCD_W-1:0]         gcd_value;
      logic signed [COEF_W-1:0] coeff_a;
      logic signed [COEF_W-1:0] coeff_b;
   } bezout_type;

   logic clock;
   logic reset;

   egcd_req_if req_chan ();
   egcd_rsp_if rsp_chan ();

   extended_gcd u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // operand pairs waiting to be offered, and bezout results still owed
   operand_pair_type operand_q[$];
   bezout_type       bezout_q[$];

   int accepted_cnt;
   int checked_cnt;
   int error_cnt;
   int gcd_above_one_cnt;
   int zero_operand_cnt;
   int longest_chain;
   int hold_seen;
   int drain_seen;

   // extended euclid on 64-bit words, coefficients wrap mod 2^64 and come out exact
   function automatic bezout_type solve_bezout(input operand_pair_type op, output int steps);
      logic [63:0] r0, r1, s0, s1, t0, t1, q, rn, sn, tn;
      bezout_type  res;
      r0 = 64'(op.a);
      r1 = 64'(op.b);
      s0 = 64'd1;
      t0 = 64'd0;
      s1 = 64'd0;
      t1 = 64'd1;
      steps = 0;
      while (r1 != 64'd0) begin
         q  = r0 / r1;
         rn = r0 % r1;
         sn = s0 - q * s1;
         tn = t0 - q * t1;
         r0 = r1;
         s0 = s1;
         t0 = t1;
         r1 = rn;
         s1 = sn;
         t1 = tn;
         steps++;
      end
      res.gcd_value = r0[GCD_W-1:0];
      res.coeff_a   = s0[COEF_W-1:0];
      res.coeff_b   = t0[COEF_W-1:0];
      return res;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // every third block of 150 transactions runs with no random idling on either side
   function automatic logic quiet_phase();
      return ((accepted_cnt / 150) % 3) == 2;
   endfunction

   function automatic logic [OPND_W-1:0] rand_bits(input int w);
      logic [31:0] v;
      v = $urandom();
      return OPND_W'(v >> (32 - w));
   endfunction

   // consecutive fibonacci numbers give the longest division chains
   function automatic operand_pair_type fib_pair(input int n);
      operand_pair_type p;
      logic [OPND_W-1:0] f0, f1, fn;
      f0 = OPND_W'(1);
      f1 = OPND_W'(1);
      for (int i = 0; i < n; i++) begin
         fn = f0 + f1;
         f0 = f1;
         f1 = fn;
      end
      p.a = f1;
      p.b = f0;
      return p;
   endfunction

   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      logic [OPND_W-1:0] g;
      int r, k;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         // full width operands
         p.a = rand_bits(OPND_W);
         p.b = rand_bits(OPND_W);
      end else if (r < 60) begin
         // mixed widths, short chains and lopsided quotients
         p.a = rand_bits($urandom_range(1, OPND_W));
         p.b = rand_bits($urandom_range(1, OPND_W));
      end else if (r < 80) begin
         // shared odd factor, so the gcd is a multiple of it
         k   = $urandom_range(1, 16);
         g   = rand_bits(k) | OPND_W'(1);
         p.a = g * rand_bits(OPND_W - k);
         p.b = g * rand_bits(OPND_W - k);
      end else if (r < 86) begin
         // operand a zero one time in three, operand b zero two times in three
         p.a = ($urandom_range(0, 2) == 0) ? '0 : rand_bits($urandom_range(1, OPND_W));
         p.b = ($urandom_range(0, 2) == 1) ? rand_bits($urandom_range(1, OPND_W)) : '0;
      end else if (r < 92) begin
         // near the top of the range
         p.a = '1 - OPND_W'($urandom_range(0, 255));
         p.b = '1 - OPND_W'($urandom_range(0, 255));
      end else if (r < 96) begin
         // equal operands or one a multiple of the other
         p.b = rand_bits($urandom_range(1, 20));
         p.a = p.b * OPND_W'($urandom_range(1, 1000));
         if ($urandom_range(0, 1) == 1) p = '{a: p.b, b: p.a};
      end else begin
         p = fib_pair($urandom_range(10, 43));
         if ($urandom_range(0, 1) == 1) p = '{a: p.b, b: p.a};
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      error_cnt++;
      if (error_cnt <= 10)
         $display("mismatch on result %0d, %s: expected %0d, got %0d",
                  checked_cnt, what, want, got);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #240ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // request driver: valid and operands held until the transaction is taken
   int  gap_left;
   logic drain_pause;
   always @(posedge clock) begin
      bezout_type       want;
      operand_pair_type op;
      int               steps;
      logic             took;
      if (reset) begin
         req_chan.valid     <= 1'b0;
         req_chan.operand_a <= '0;
         req_chan.operand_b <= '0;
         gap_left    = 0;
         drain_pause = 1'b0;
      end else begin
         took = req_chan.valid && req_chan.ready;
         if (took) begin
            op   = operand_q.pop_front();
            want = solve_bezout(op, steps);
            bezout_q.push_back(want);
            accepted_cnt++;
            if (steps > longest_chain) longest_chain = steps;
            if (want.gcd_value > GCD_W'(1)) gcd_above_one_cnt++;
            if (op.a == '0 || op.b == '0) zero_operand_cnt++;
            gap_left = quiet_phase() ? 0 : pick_gap();
            // hold the sender once until every owed result is back
            if (accepted_cnt == DRAIN_AT) drain_pause = 1'b1;
         end
         if (!req_chan.valid || took) begin
            if (drain_pause) begin
               if (bezout_q.size() == 0) begin
                  drain_pause = 1'b0;
                  drain_seen++;
               end
               req_chan.valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (operand_q.size() > 0) begin
               req_chan.valid     <= 1'b1;
               req_chan.operand_a <= operand_q[0].a;
               req_chan.operand_b <= operand_q[0].b;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result ready: random stalls plus one long hold-off so the block backs up
   int  stall_left;
   int  hold_left;
   logic hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         hold_seen = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet_phase() && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
   end

   // result monitor: each transaction checked against the oldest owed result
   always @(posedge clock) begin
      bezout_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (bezout_q.size() == 0) begin
            error_cnt++;
            if (error_cnt <= 10)
               $display("result transaction with nothing owed: gcd %0d x %0d y %0d",
                        rsp_chan.gcd_value, rsp_chan.coeff_a, rsp_chan.coeff_b);
         end else begin
            want = bezout_q.pop_front();
            if (rsp_chan.gcd_value !== want.gcd_value)
               report_mismatch("gcd_value", longint'(want.gcd_value),
                               longint'(rsp_chan.gcd_value));
            if (rsp_chan.coeff_a !== want.coeff_a)
               report_mismatch("coeff_a", longint'(want.coeff_a), longint'(rsp_chan.coeff_a));
            if (rsp_chan.coeff_b !== want.coeff_b)
               report_mismatch("coeff_b", longint'(want.coeff_b), longint'(rsp_chan.coeff_b));
            checked_cnt++;
         end
      end
   end

   // stimulus and end of run
   initial begin
      operand_pair_type p;
      int               total_err;
      reset = 1'b1;

      // directed: zero operands, extremes, worst chains, trivial and shared factors
      operand_q.push_back('{a: '0, b: '0});
      operand_q.push_back('{a: 31'd5, b: '0});
      operand_q.push_back('{a: '0, b: 31'd7});
      operand_q.push_back('{a: '1, b: '0});
      operand_q.push_back('{a: '0, b: '1});
      operand_q.push_back('{a: '1, b: '1});
      operand_q.push_back('{a: '1, b: 31'd1});
      operand_q.push_back('{a: 31'd1, b: '1});
      operand_q.push_back('{a: '1, b: '1 - 31'd1});
      operand_q.push_back('{a: 31'd1836311903, b: 31'd1134903170});
      operand_q.push_back('{a: 31'd1134903170, b: 31'd1836311903});
      operand_q.push_back('{a: 31'd240, b: 31'd46});
      operand_q.push_back('{a: 31'd46, b: 31'd240});
      operand_q.push_back('{a: 31'd12, b: 31'd12});
      operand_q.push_back('{a: 31'h40000000, b: 31'h00010000});
      operand_q.push_back('{a: 31'h55555555, b: 31'h2aaaaaaa});
      operand_q.push_back('{a: 31'h2aaaaaaa, b: 31'h55555555});
      operand_q.push_back('{a: 31'd99991, b: 31'd99989});
      operand_q.push_back('{a: 31'd1, b: 31'd1});
      operand_q.push_back('{a: 31'd3, b: 31'd1});
      p = fib_pair(20);
      operand_q.push_back(p);
      for (int i = 0; i < RANDOM_ITEMS; i++) operand_q.push_back(random_pair());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (operand_q.size() != 0 || bezout_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      total_err = error_cnt + bezout_q.size();
      $display("covered %0d transactions, %0d results checked, %0d with gcd above one,",
               accepted_cnt, checked_cnt, gcd_above_one_cnt);
      $display("%0d with a zero operand, longest chain %0d division steps,",
               zero_operand_cnt, longest_chain);
      $display("receiver hold-off %0d cycles, sender drains %0d", hold_seen, drain_seen);
      if (total_err == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d errors", total_err);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
